// ----- design/chm_pkg.sv -----
// shared constants for the chained hash map core
`timescale 1ns / 1ps
package chm_pkg;
  localparam int ENTRIES_DEF    = 1024;
  localparam int BUCKETS_DEF    = 2048;
  localparam int VALUE_BITS_DEF = 32;

  localparam int KEY_W     = 31;
  localparam int PAYLOAD_W = 32;
  localparam int BC_W      = 12;
  localparam int CAP_W     = 11;
  localparam int KCNT_W    = 5;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  localparam logic REG_BUCKET_COUNT = 1'b0;
  localparam logic REG_CAPACITY     = 1'b1;

  localparam logic [BC_W-1:0]  BC_RESET  = 12'd2048;
  localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;
endpackage

// ----- design/chm_mod_unit.sv -----
// bit-serial remainder unit: key modulo bucket count, one key bit per cycle
`timescale 1ns / 1ps
module chm_mod_unit #(
  parameter int BUCKETS = chm_pkg::BUCKETS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               go,
  input  logic [chm_pkg::KEY_W-1:0]          dividend,
  input  logic [$clog2(BUCKETS+1)-1:0]       divisor,
  output logic                               done,
  output logic [$clog2(BUCKETS)-1:0]         remainder
);
  localparam int DW = $clog2(BUCKETS + 1);
  localparam int HB = $clog2(BUCKETS);

  logic [DW-1:0]                 rem_r, rem_nxt;
  logic [DW-1:0]                 div_r;
  logic [chm_pkg::KEY_W-1:0]     key_r, key_nxt;
  logic [chm_pkg::KCNT_W-1:0]    cnt_r, cnt_nxt;
  logic                          run_r, run_nxt;
  logic                          done_r, done_nxt;
  logic [DW:0]                   trial;
  logic [DW:0]                   diff;

  assign trial = {rem_r, key_r[chm_pkg::KEY_W-1]};
  assign diff  = trial - {1'b0, div_r};

  always_comb begin
    rem_nxt  = rem_r;
    key_nxt  = key_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (go) begin
      rem_nxt = '0;
      key_nxt = dividend;
      cnt_nxt = chm_pkg::KCNT_W'(chm_pkg::KEY_W - 1);
      run_nxt = 1'b1;
    end else if (run_r) begin
      rem_nxt = (trial >= {1'b0, div_r}) ? diff[DW-1:0] : trial[DW-1:0];
      key_nxt = {key_r[chm_pkg::KEY_W-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    key_r <= key_nxt;
    cnt_r <= cnt_nxt;
    if (go) begin
      div_r <= divisor;
    end
  end

  assign done      = done_r;
  assign remainder = rem_r[HB-1:0];
endmodule

// ----- design/chained_hash_map_insert_find_core.sv -----
// chained hash map core: sequencer, bucket head memory, entry pool and config registers
// a key's bucket remainder is computed bit-serially, then its bucket head is read; an
// insert then finishes, and a lookup reads and compares one chain entry at a time
// until a match or the end of the chain; one item at a time, busy high meanwhile
// results are strobed for one cycle on out_valid; the receiver cannot stall
// after reset all BUCKETS bucket heads are cleared, one per cycle
`timescale 1ns / 1ps
module chained_hash_map_insert_find_core #(
  parameter int ENTRIES    = chm_pkg::ENTRIES_DEF,
  parameter int BUCKETS    = chm_pkg::BUCKETS_DEF,
  parameter int VALUE_BITS = chm_pkg::VALUE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic                            in_func,
  input  logic [chm_pkg::KEY_W-1:0]       in_key,
  input  logic [chm_pkg::PAYLOAD_W-1:0]   in_payload,
  output logic                            out_valid,
  output logic                            out_found,
  output logic [chm_pkg::PAYLOAD_W-1:0]   out_found_value,
  output logic                            out_dropped_full,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [2:0]                      paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  localparam int DW = $clog2(BUCKETS + 1);
  localparam int HB = $clog2(BUCKETS);
  localparam int EB = $clog2(ENTRIES);
  localparam int FW = $clog2(ENTRIES + 1);
  localparam int CW = (DW > chm_pkg::BC_W) ? DW : chm_pkg::BC_W;
  localparam int PW = (FW > chm_pkg::CAP_W) ? FW : chm_pkg::CAP_W;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_MOD   = 7'b0000100,
    S_HREAD = 7'b0001000,
    S_HUSE  = 7'b0010000,
    S_EREAD = 7'b0100000,
    S_EUSE  = 7'b1000000
  } state_t;

  typedef struct packed {
    logic          vld;
    logic [EB-1:0] idx;
  } head_t;

  typedef struct packed {
    logic [chm_pkg::KEY_W-1:0] key;
    logic [VALUE_BITS-1:0]     val;
    logic                      lvld;
    logic [EB-1:0]             link;
  } entry_t;

  // config registers
  logic [chm_pkg::BC_W-1:0]  bc_r;
  logic [chm_pkg::CAP_W-1:0] cap_r;
  logic                      cfg_wr;
  assign cfg_wr = psel & penable & pwrite;
  assign pready = 1'b1;
  always_comb begin
    unique case (paddr[2])
      chm_pkg::REG_BUCKET_COUNT: prdata = 32'(bc_r);
      chm_pkg::REG_CAPACITY:     prdata = 32'(cap_r);
      default:                   prdata = '0;
    endcase
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bc_r  <= chm_pkg::BC_RESET;
      cap_r <= chm_pkg::CAP_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == chm_pkg::REG_BUCKET_COUNT) begin
        bc_r <= pwdata[chm_pkg::BC_W-1:0];
      end else begin
        cap_r <= pwdata[chm_pkg::CAP_W-1:0];
      end
    end
  end

  // effective bucket count and capacity
  logic [CW-1:0] bc_ext;
  logic [DW-1:0] eff_bc;
  logic [PW-1:0] cap_ext;
  logic [FW-1:0] eff_cap;
  assign bc_ext  = CW'(bc_r);
  assign cap_ext = PW'(cap_r);
  always_comb begin
    priority if (bc_ext == '0) begin
      eff_bc = DW'(1);
    end else if (bc_ext > CW'(BUCKETS)) begin
      eff_bc = DW'(BUCKETS);
    end else begin
      eff_bc = bc_ext[DW-1:0];
    end
    if (cap_ext > PW'(ENTRIES)) begin
      eff_cap = FW'(ENTRIES);
    end else begin
      eff_cap = cap_ext[FW-1:0];
    end
  end

  // sequencer state
  state_t                    state_r, state_nxt;
  logic [HB-1:0]             clr_r, clr_nxt;
  logic [FW-1:0]             fill_r, fill_nxt;
  logic                      func_r;
  logic [chm_pkg::KEY_W-1:0] key_r;
  logic [VALUE_BITS-1:0]     val_r;
  logic [HB-1:0]             bkt_r, bkt_nxt;
  logic [EB-1:0]             idx_r, idx_nxt;
  logic                      ov_nxt, of_nxt, od_nxt;
  logic [chm_pkg::PAYLOAD_W-1:0] ofv_nxt;
  logic                      accept;
  logic                      mod_done;
  logic [HB-1:0]             mod_rem;

  // memories
  head_t  heads [BUCKETS];
  entry_t pool  [ENTRIES];
  head_t  head_q;
  entry_t ent_q;
  logic          h_we;
  logic [HB-1:0] h_wa;
  head_t         h_wd;
  logic          e_we;
  entry_t        e_wd;

  assign accept = start & (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);

  chm_mod_unit #(.BUCKETS(BUCKETS)) u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (accept),
    .dividend  (in_key),
    .divisor   (eff_bc),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    fill_nxt  = fill_r;
    bkt_nxt   = bkt_r;
    idx_nxt   = idx_r;
    ov_nxt    = 1'b0;
    of_nxt    = 1'b0;
    od_nxt    = 1'b0;
    ofv_nxt   = '0;
    h_we      = 1'b0;
    h_wa      = bkt_r;
    h_wd      = '{vld: 1'b1, idx: fill_r[EB-1:0]};
    e_we      = 1'b0;
    e_wd      = '{key: key_r, val: val_r, lvld: head_q.vld, link: head_q.idx};
    unique case (state_r)
      S_CLEAR: begin
        h_we    = 1'b1;
        h_wa    = clr_r;
        h_wd    = '0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == HB'(BUCKETS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          state_nxt = S_MOD;
        end
      end
      S_MOD: begin
        if (mod_done) begin
          bkt_nxt   = mod_rem;
          state_nxt = S_HREAD;
        end
      end
      S_HREAD: begin
        state_nxt = S_HUSE;
      end
      S_HUSE: begin
        if (func_r == chm_pkg::FUNC_INSERT) begin
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
          if (fill_r >= eff_cap) begin
            od_nxt = 1'b1;
          end else begin
            h_we     = 1'b1;
            e_we     = 1'b1;
            fill_nxt = fill_r + 1'b1;
          end
        end else if (head_q.vld && (FW'(head_q.idx) < fill_r)) begin
          idx_nxt   = head_q.idx;
          state_nxt = S_EREAD;
        end else begin
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_EREAD: begin
        state_nxt = S_EUSE;
      end
      S_EUSE: begin
        if (ent_q.key == key_r) begin
          ov_nxt    = 1'b1;
          of_nxt    = 1'b1;
          ofv_nxt   = chm_pkg::PAYLOAD_W'(ent_q.val);
          state_nxt = S_IDLE;
        end else if (ent_q.lvld && (FW'(ent_q.link) < fill_r)) begin
          idx_nxt   = ent_q.link;
          state_nxt = S_EREAD;
        end else begin
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= S_CLEAR;
      clr_r            <= '0;
      fill_r           <= '0;
      out_valid        <= 1'b0;
      out_found        <= 1'b0;
      out_found_value  <= '0;
      out_dropped_full <= 1'b0;
    end else begin
      state_r          <= state_nxt;
      clr_r            <= clr_nxt;
      fill_r           <= fill_nxt;
      out_valid        <= ov_nxt;
      out_found        <= of_nxt;
      out_found_value  <= ofv_nxt;
      out_dropped_full <= od_nxt;
    end
    bkt_r <= bkt_nxt;
    idx_r <= idx_nxt;
    if (accept) begin
      func_r <= in_func;
      key_r  <= in_key;
      val_r  <= VALUE_BITS'(in_payload);
    end
  end

  always_ff @(posedge clk) begin
    if (h_we) begin
      heads[h_wa] <= h_wd;
    end
    head_q <= heads[bkt_r];
  end

  always_ff @(posedge clk) begin
    if (e_we) begin
      pool[fill_r[EB-1:0]] <= e_wd;
    end
    ent_q <= pool[idx_r];
  end
endmodule
